### rtl/core/ecv_pkg.sv
// shared types and constants for the encoder counter with velocity
package ecv_pkg;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic ms_tick;
        logic velocity_request;
        logic clear_count;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] total_count;
        logic signed [31:0] ticks_per_second;
        logic signed [31:0] speed;
    } t_out_item;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MPT    = 3'd5;

    // 1000 * 65536
    localparam logic [25:0] VEL_SCALE = 26'd65536000;
    localparam int DIV_STEPS = 58;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_AVG,
        ST_SPEED,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic take;      // capture item, apply counting and clear
        logic div_start; // load divider
        logic div_step;  // one restoring step
        logic finish;    // write velocity result
        logic avg_mul;   // ema multiply stage
        logic speed_mul; // speed multiply stage
        logic out_load;  // load output register
    } t_cmd;

    typedef struct packed {
        logic need_div;  // velocity request that updates
        logic div_last;
        logic ema;       // result goes through average
    } t_status;

endpackage

### rtl/core/ecv_ctrl.sv
// controller state machine for the encoder counter
module ecv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ecv_pkg::t_status i_status,
    output ecv_pkg::t_cmd    o_cmd
);
    import ecv_pkg::*;

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        o_in_ready = 1'b0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = ST_SPEED;
                    if (i_status.need_div) begin
                        o_cmd.div_start = 1'b1;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = i_status.ema ? ST_AVG : ST_SPEED;
            end
            ST_AVG: begin
                o_cmd.avg_mul = 1'b1;
                n_state = ST_SPEED;
            end
            ST_SPEED: begin
                o_cmd.finish = 1'b1;
                o_cmd.speed_mul = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

### rtl/core/ecv_dp.sv
// datapath: filters, counter, time base, divider, average and speed
module ecv_dp #(
    parameter int HW_LIMIT = 10000,
    parameter int TIME_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ecv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ecv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  ecv_pkg::t_in_item                 i_item,
    input  ecv_pkg::t_cmd                     i_cmd,
    output ecv_pkg::t_status                  o_status,
    output ecv_pkg::t_out_item                o_item
);
    import ecv_pkg::*;

    localparam int HW_W = $clog2(HW_LIMIT + 1) + 1;
    localparam logic signed [HW_W-1:0] HW_POS = HW_W'(HW_LIMIT);
    localparam logic signed [HW_W-1:0] HW_NEG = -HW_W'(HW_LIMIT);
    localparam int NUM_W = 58;
    localparam int STEP_W = $clog2(DIV_STEPS);

    // configuration
    logic        r_invert;
    logic [9:0]  r_filter;
    logic        r_mode;
    logic [15:0] r_window;
    logic [16:0] r_alpha;
    logic [31:0] r_mpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
            r_filter <= '0;
            r_mode <= 1'b1;
            r_window <= 16'd20;
            r_alpha <= 17'd32768;
            r_mpt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INVERT: r_invert <= i_cfg_data[0];
                REG_FILTER: r_filter <= i_cfg_data[9:0];
                REG_MODE:   r_mode <= i_cfg_data[0];
                REG_WINDOW: r_window <= i_cfg_data[15:0];
                REG_ALPHA:  r_alpha <= i_cfg_data[16:0];
                REG_MPT:    r_mpt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state
    logic signed [HW_W-1:0] r_hw;
    logic [31:0] r_ovf;
    logic [1:0]  r_lvl;
    logic [9:0]  r_stab [2];
    logic [TIME_WIDTH-1:0] r_time, r_last_time;
    logic [31:0] r_last_cnt;
    logic signed [31:0] r_win_vel, r_avg_vel;
    logic r_started;

    // combinational step
    logic [TIME_WIDTH-1:0] n_time, n_last_time, dt;
    logic [1:0] n_lvl;
    logic [9:0] n_stab [2];
    logic signed [HW_W-1:0] n_hw, hw_inc;
    logic [31:0] n_ovf, n_last_cnt, tot, now;
    logic signed [31:0] n_win_vel;
    logic [1:0] raw;
    logic [10:0] cnt_inc;
    logic [15:0] win;
    logic upd;

    assign raw = {i_item.pin_b, i_item.pin_a};

    always_comb begin
        n_time = i_item.ms_tick ? r_time + 1'b1 : r_time;
        n_lvl = r_lvl;
        for (int i = 0; i < 2; i++) begin
            cnt_inc = {1'b0, r_stab[i]} + 11'd1;
            if (raw[i] == r_lvl[i]) begin
                n_stab[i] = '0;
            end else if (cnt_inc >= {1'b0, r_filter}) begin
                n_lvl[i] = ~r_lvl[i];
                n_stab[i] = '0;
            end else begin
                n_stab[i] = cnt_inc[9:0];
            end
        end
        n_hw = r_hw;
        n_ovf = r_ovf;
        hw_inc = r_hw;
        if (n_lvl[0] != r_lvl[0]) begin
            hw_inc = (r_lvl[1] ^ r_lvl[0]) ? r_hw + HW_W'(1) : r_hw - HW_W'(1);
            if (hw_inc >= HW_POS) begin
                n_hw = '0;
                n_ovf = r_ovf + 32'(HW_LIMIT);
            end else if (hw_inc <= HW_NEG) begin
                n_hw = '0;
                n_ovf = r_ovf - 32'(HW_LIMIT);
            end else begin
                n_hw = hw_inc;
            end
        end
        n_last_cnt = r_last_cnt;
        n_last_time = r_last_time;
        n_win_vel = r_win_vel;
        if (i_item.clear_count) begin
            n_hw = '0;
            n_ovf = '0;
            n_last_cnt = '0;
            n_last_time = n_time;
            n_win_vel = '0;
        end
        tot = n_ovf + 32'(n_hw);
        now = r_invert ? 32'd0 - tot : tot;
        dt = n_time - n_last_time;
        win = (r_window == '0) ? 16'd1 : r_window;
        if (r_mode == 1'b0)
            upd = i_item.velocity_request && (32'(dt) >= 32'(win));
        else
            upd = i_item.velocity_request && (dt != '0);
    end

    // serial divider operands
    logic [NUM_W-1:0] r_quo;
    logic [TIME_WIDTH:0] r_rem;
    logic [TIME_WIDTH-1:0] r_den;
    logic r_neg, r_ema_path;
    logic [STEP_W-1:0] r_step;
    logic [TIME_WIDTH:0] trial;
    logic signed [31:0] dc;
    logic [31:0] dmag;
    logic [NUM_W-1:0] num_mag;
    logic signed [31:0] raw_vel, r_raw, new_vel;
    logic [57:0] qsat;
    logic signed [48:0] r_prod_a, r_prod_b;
    logic signed [50:0] ema_sum;
    logic [50:0] ema_mag;
    logic signed [63:0] r_sp;
    logic signed [31:0] vel_sel;
    logic [63:0] sp_mag;
    logic signed [32:0] sp_tr;
    logic signed [31:0] sp_sat;
    logic signed [31:0] tot_q;
    logic r_new_vel_ok;
    // velocity chosen for this item before the speed multiply
    logic signed [31:0] vel_next;
    logic signed [50:0] ema_q;

    assign dc = $signed(now - n_last_cnt);
    assign dmag = dc[31] ? 32'd0 - now + n_last_cnt : now - n_last_cnt;
    assign num_mag = NUM_W'(dmag) * NUM_W'(VEL_SCALE);
    assign trial = {r_rem[TIME_WIDTH-1:0], r_quo[NUM_W-1]};

    // quotient saturates to int32 range, sign applied
    always_comb begin
        qsat = r_quo;
        if (r_neg) raw_vel = (qsat > 58'h80000000) ? 32'sh80000000 : -$signed(qsat[31:0]);
        else       raw_vel = (qsat > 58'h7fffffff) ? 32'sh7fffffff : $signed(qsat[31:0]);
    end

    always_comb begin
        ema_sum = 51'(r_prod_a) + 51'(r_prod_b);
        ema_mag = ema_sum[50] ? 51'd0 - 51'(ema_sum) : 51'(ema_sum);
        vel_sel = r_mode ? r_avg_vel : r_win_vel;
        sp_mag = r_sp[63] ? 64'd0 - 64'(r_sp) : 64'(r_sp);
        sp_tr = r_sp[63] ? -$signed({1'b0, sp_mag[63:32]}) : $signed({1'b0, sp_mag[63:32]});
        sp_sat = (sp_tr > 33'sd2147483647) ? 32'sh7fffffff
               : (sp_tr < -33'sd2147483648) ? 32'sh80000000 : sp_tr[31:0];
        tot_q = $signed(r_invert ? 32'd0 - (r_ovf + 32'(r_hw)) : r_ovf + 32'(r_hw));
    end

    logic [16:0] alpha_c;
    assign alpha_c = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= '0;
            r_ovf <= '0;
            r_lvl <= '0;
            r_stab[0] <= '0;
            r_stab[1] <= '0;
            r_time <= '0;
            r_last_time <= '0;
            r_last_cnt <= '0;
            r_win_vel <= '0;
            r_avg_vel <= '0;
            r_started <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_time <= n_time;
                r_lvl <= n_lvl;
                r_stab[0] <= n_stab[0];
                r_stab[1] <= n_stab[1];
                r_hw <= n_hw;
                r_ovf <= n_ovf;
                r_win_vel <= n_win_vel;
                r_last_cnt <= upd ? now : n_last_cnt;
                r_last_time <= upd ? n_time : n_last_time;
            end
            if (i_cmd.finish && r_ema_path) begin
                r_avg_vel <= new_vel;
                r_started <= 1'b1;
            end
            if (i_cmd.finish && !r_ema_path && r_new_vel_ok)
                r_win_vel <= new_vel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_vel_ok <= 1'b0;
        end else if (i_cmd.take) begin
            r_new_vel_ok <= upd;
        end
        if (i_cmd.div_start) begin
            r_quo <= num_mag;
            r_rem <= '0;
            r_den <= dt;
            r_neg <= dc[31];
            r_step <= '0;
            r_ema_path <= r_mode;
        end else if (i_cmd.take) begin
            r_ema_path <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_step <= r_step + 1'b1;
            if (trial >= {1'b0, r_den}) begin
                r_rem <= trial - {1'b0, r_den};
                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
            end
        end
        // raw velocity lands once division completes
        if (i_cmd.avg_mul) begin
            r_raw <= raw_vel;
            r_prod_a <= $signed({1'b0, alpha_c}) * raw_vel;
            r_prod_b <= $signed({1'b0, 17'd65536 - alpha_c}) * r_avg_vel;
        end
        if (i_cmd.speed_mul) begin
            r_sp <= vel_next * $signed({1'b0, r_mpt});
        end
        if (i_cmd.out_load) begin
            o_item.total_count <= tot_q;
            o_item.ticks_per_second <= vel_sel;
            o_item.speed <= sp_sat;
        end
    end

    always_comb begin
        ema_q = ema_sum[50] ? -$signed({1'b0, ema_mag[50:16]}) : $signed({1'b0, ema_mag[50:16]});
        if (r_ema_path) begin
            if (!r_started) new_vel = r_raw;
            else if (ema_q > 51'sd2147483647) new_vel = 32'sh7fffffff;
            else if (ema_q < -51'sd2147483648) new_vel = 32'sh80000000;
            else new_vel = ema_q[31:0];
        end else begin
            new_vel = raw_vel;
        end
        if (r_new_vel_ok) vel_next = new_vel;
        else vel_next = r_mode ? r_avg_vel : r_win_vel;
    end

    assign o_status.need_div = upd;
    assign o_status.div_last = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_status.ema = r_ema_path;
endmodule

### rtl/core/encoder_count_and_velocity.sv
// top level of the quadrature encoder counter with velocity estimate
// each item: idle, speed, output; an update adds divide and, in mode 1, average
// throughput: one item at a time; the 58-step serial divider sets the long case
// the speed multiply and the output register follow as registered steps
// reset: synchronous active low, clears counts, filters, time and velocity state
// configuration registers return to their listed defaults on reset
module encoder_count_and_velocity #(
    parameter int HW_LIMIT = 10000,
    parameter int TIME_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ecv_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ecv_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_we,
    input  logic [ecv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ecv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ecv_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: idle, divide, average, speed, output
    ecv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // counting, time base and velocity arithmetic
    ecv_dp #(
        .HW_LIMIT   (HW_LIMIT),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_item     (o_out_item)
    );
endmodule

### test/tb_top.sv
// testbench for the quadrature encoder counter with velocity estimate
`timescale 1ns / 100ps

module tb_top;
    import ecv_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_ready;
    t_in_item    in_item;
    logic        o_out_valid;
    logic        out_ready;
    t_out_item   o_out_item;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    encoder_count_and_velocity dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predicted register copies
    logic        r_invert;
    logic [9:0]  r_filter;
    logic        r_mode;
    logic [15:0] r_window;
    logic [16:0] r_alpha;
    logic [31:0] r_mpt;

    // predicted block state
    int          enc_hw;
    logic [31:0] enc_over;
    logic [1:0]  enc_levels;
    logic [9:0]  enc_stable [2];
    logic [31:0] enc_time;
    logic [31:0] enc_last_count;
    logic [31:0] enc_last_time;
    logic signed [31:0] enc_win_vel;
    logic signed [31:0] enc_avg_vel;
    logic        enc_avg_started;

    t_out_item   pending_results [$];
    int          mismatches;
    int          hold_left;
    logic        tx_idle_on;
    logic        rx_idle_on;
    int          quad_idx;
    int          quad_dir;

    // quadrature pin pattern {a,b}; stepping forward counts up on every a edge
    logic [1:0]  quad_pattern [4] = '{2'b01, 2'b11, 2'b10, 2'b00};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // generous watchdog
    initial begin
        #20_000_000;
        $display("encoder_count_and_velocity verification failed");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] count_total();
        logic [31:0] t;
        t = enc_over + 32'(enc_hw);
        return r_invert ? -t : t;
    endfunction

    // ticks per second in q16.16 from count change over elapsed ms
    function automatic logic signed [31:0] tick_rate(logic [31:0] dcount, logic [31:0] dt);
        longint num;
        num = longint'($signed(dcount)) * 64'sd65536000;
        return clamp32(num / $signed({32'b0, dt}));
    endfunction

    function automatic void debounce_pin(int i, logic raw);
        logic [10:0] n;
        if (raw == enc_levels[i]) begin
            enc_stable[i] = '0;
        end else begin
            n = 11'(enc_stable[i]) + 11'd1;
            if (n >= 11'(r_filter)) begin
                enc_levels[i] = ~enc_levels[i];
                enc_stable[i] = '0;
            end else begin
                enc_stable[i] = n[9:0];
            end
        end
    endfunction

    function automatic t_out_item encoder_predict(t_in_item it);
        logic        old_a;
        logic        old_b;
        int          d;
        logic [31:0] dt;
        logic [31:0] now;
        logic [31:0] win;
        logic signed [31:0] raw;
        logic signed [31:0] vel;
        longint      a;
        longint      s;
        longint      sp;
        t_out_item   r;
        if (it.ms_tick) enc_time = enc_time + 32'd1;
        old_a = enc_levels[0];
        old_b = enc_levels[1];
        debounce_pin(0, it.pin_a);
        debounce_pin(1, it.pin_b);
        if (enc_levels[0] != old_a) begin
            // rising a with b high counts up, falling a reverses it
            d = old_b ? 1 : -1;
            if (old_a) d = -d;
            enc_hw = enc_hw + d;
            if (enc_hw >= 10000) begin
                enc_hw = 0;
                enc_over = enc_over + 32'd10000;
            end else if (enc_hw <= -10000) begin
                enc_hw = 0;
                enc_over = enc_over - 32'd10000;
            end
        end
        if (it.clear_count) begin
            enc_hw = 0;
            enc_over = '0;
            enc_last_count = '0;
            enc_last_time = enc_time;
            enc_win_vel = '0;
        end
        if (it.velocity_request) begin
            dt = enc_time - enc_last_time;
            now = count_total();
            win = (r_window == 0) ? 32'd1 : 32'(r_window);
            if (!r_mode) begin
                if (dt >= win) begin
                    enc_win_vel = tick_rate(now - enc_last_count, dt);
                    enc_last_count = now;
                    enc_last_time = enc_time;
                end
            end else if (dt != 0) begin
                raw = tick_rate(now - enc_last_count, dt);
                if (!enc_avg_started) begin
                    enc_avg_vel = raw;
                    enc_avg_started = 1'b1;
                end else begin
                    a = (r_alpha > 17'd65536) ? 64'sd65536 : longint'(r_alpha);
                    s = a * longint'(raw) + (64'sd65536 - a) * longint'(enc_avg_vel);
                    enc_avg_vel = clamp32(s / 64'sd65536);
                end
                enc_last_count = now;
                enc_last_time = enc_time;
            end
        end
        vel = r_mode ? enc_avg_vel : enc_win_vel;
        sp = (longint'(vel) * $signed({32'b0, r_mpt})) / 64'sh1_0000_0000;
        r.total_count = count_total();
        r.ticks_per_second = vel;
        r.speed = clamp32(sp);
        return r;
    endfunction

    // receiver: random stalls, or a long hold-off counted down here
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ready = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                out_ready = !rx_idle_on || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result item: %p", o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.total_count !== want.total_count ||
                    o_out_item.ticks_per_second !== want.ticks_per_second ||
                    o_out_item.speed !== want.speed) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected cnt %0d tps %0d spd %0d, got %0d %0d %0d",
                            want.total_count, want.ticks_per_second, want.speed,
                            o_out_item.total_count, o_out_item.ticks_per_second,
                            o_out_item.speed);
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(t_in_item it);
        if (tx_idle_on && $urandom_range(0, 99) < 20) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item = it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(encoder_predict(it));
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            REG_INVERT: r_invert = value[0];
            REG_FILTER: r_filter = value[9:0];
            REG_MODE:   r_mode = value[0];
            REG_WINDOW: r_window = value[15:0];
            REG_ALPHA:  r_alpha = value[16:0];
            REG_MPT:    r_mpt = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic inv, logic [9:0] filt, logic mode, logic [15:0] win,
                             logic [16:0] alpha, logic [31:0] mpt);
        wait_drained();
        write_reg(REG_INVERT, 32'(inv));
        write_reg(REG_FILTER, 32'(filt));
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_WINDOW, 32'(win));
        write_reg(REG_ALPHA, 32'(alpha));
        write_reg(REG_MPT, mpt);
    endtask

    function automatic t_in_item make_item(logic [1:0] pins, logic tick, logic vreq,
                                           logic clr);
        t_in_item it;
        it.pin_a = pins[1];
        it.pin_b = pins[0];
        it.ms_tick = tick;
        it.velocity_request = vreq;
        it.clear_count = clr;
        return it;
    endfunction

    // one quadrature move held long enough to pass the filter, random side fields
    task automatic quad_move(int dir, int vreq_pct);
        int hold;
        quad_idx = (quad_idx + dir + 4) % 4;
        hold = (r_filter > 1 ? int'(r_filter) : 1) + $urandom_range(0, 2);
        repeat (hold)
            send_item(make_item(quad_pattern[quad_idx], 1'($urandom_range(0, 1)),
                                $urandom_range(0, 99) < vreq_pct,
                                $urandom_range(0, 199) == 0));
    endtask

    // edges, clear, time and both velocity paths with the filter off
    task automatic test_directed();
        configure(1'b0, 10'd0, 1'b0, 16'd1, 17'd32768, 32'hffff_ffff);
        quad_idx = 3;
        repeat (4) begin
            quad_idx = (quad_idx + 1) % 4;
            send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b0, 1'b0));
        end
        send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b1, 1'b0));
        // reverse direction
        repeat (3) begin
            quad_idx = (quad_idx + 3) % 4;
            send_item(make_item(quad_pattern[quad_idx], 1'b0, 1'b0, 1'b0));
        end
        // request with no elapsed time leaves windowed velocity alone
        send_item(make_item(quad_pattern[quad_idx], 1'b0, 1'b1, 1'b0));
        send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b1, 1'b0));
        // both pins change at once, a edge uses the old b level
        send_item(make_item(~quad_pattern[quad_idx], 1'b1, 1'b1, 1'b0));
        // clear together with an edge loses the edge
        send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b0, 1'b1));
        send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b1, 1'b1));
        configure(1'b1, 10'd1, 1'b1, 16'd0, 17'h1ffff, 32'h8000_0000);
        repeat (6) quad_move(1, 50);
        send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b1, 1'b0));
        send_item(make_item(quad_pattern[quad_idx], 1'b0, 1'b1, 1'b0));
    endtask

    // random phases over a spread of register settings
    task automatic test_random_phases();
        int items;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(1'b0, 10'd0, 1'b0, 16'd1, 17'd0, 32'h0000_0000);
                1: configure(1'b1, 10'd2, 1'b1, 16'd20, 17'd65536, 32'h1000_0000);
                2: configure(1'b0, 10'd3, 1'b1, 16'd5, 17'd0, 32'hffff_ffff);
                3: configure(1'b1, 10'd0, 1'b0, 16'd65535, 17'd1, 32'd1);
                4: configure(1'b0, 10'd1, 1'b1, 16'd1, 17'h1ffff, $urandom);
                default: configure(1'($urandom), 10'($urandom_range(0, 4)),
                                   1'($urandom), 16'($urandom_range(0, 40)),
                                   17'($urandom_range(0, 131071)), $urandom);
            endcase
            // long run without idling in the middle phase
            tx_idle_on = (ph != 4);
            rx_idle_on = (ph != 4);
            items = 0;
            while (items < 100) begin
                if ($urandom_range(0, 99) < 70) begin
                    if ($urandom_range(0, 99) < 10) quad_dir = -quad_dir;
                    quad_move(quad_dir, 20);
                    items = items + 1 + (r_filter > 1 ? int'(r_filter) : 1);
                end else begin
                    send_item(make_item(2'($urandom), 1'($urandom), 1'($urandom),
                                        $urandom_range(0, 49) == 0));
                    items = items + 1;
                end
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, then a full pause
    task automatic test_backpressure();
        configure(1'b0, 10'd0, 1'b1, 16'd1, 17'd20000, 32'h0123_4567);
        hold_left = 300;
        tx_idle_on = 1'b0;
        repeat (40) quad_move(1, 30);
        tx_idle_on = 1'b1;
        wait_drained();
        repeat (20) quad_move(-1, 30);
    endtask

    // maximum filter length: levels need 1023 differing samples
    task automatic test_slow_filter();
        configure(1'b0, 10'd1023, 1'b0, 16'd2, 17'd0, 32'h4000_0000);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        quad_move(1, 2);
        // a glitch shorter than the filter is ignored
        repeat (60) send_item(make_item(~quad_pattern[quad_idx], 1'b1, 1'b0, 1'b0));
        send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b1, 1'b0));
    endtask

    // long runs in one direction, plain and inverted
    task automatic test_long_runs();
        configure(1'b0, 10'd0, 1'b0, 16'd50, 17'd0, 32'h0001_0000);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (100) begin
            quad_idx = (quad_idx + 1) % 4;
            send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b0, 1'b0));
        end
        send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b1, 1'b0));
        configure(1'b1, 10'd0, 1'b0, 16'd50, 17'd0, 32'h0001_0000);
        repeat (100) begin
            quad_idx = (quad_idx + 3) % 4;
            send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b0, 1'b0));
        end
        send_item(make_item(quad_pattern[quad_idx], 1'b1, 1'b1, 1'b0));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        mismatches = 0;
        hold_left = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        quad_idx = 3;
        quad_dir = 1;
        // predictor at its reset values
        r_invert = 1'b0;
        r_filter = 10'd0;
        r_mode = 1'b1;
        r_window = 16'd20;
        r_alpha = 17'd32768;
        r_mpt = '0;
        enc_hw = 0;
        enc_over = '0;
        enc_levels = '0;
        enc_stable[0] = '0;
        enc_stable[1] = '0;
        enc_time = '0;
        enc_last_count = '0;
        enc_last_time = '0;
        enc_win_vel = '0;
        enc_avg_vel = '0;
        enc_avg_started = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // default registers first, before any write
        repeat (10) quad_move(1, 30);
        test_directed();
        test_random_phases();
        test_backpressure();
        test_slow_filter();
        test_long_runs();

        wait_drained();
        repeat (70) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("encoder_count_and_velocity verification clean");
        else
            $display("encoder_count_and_velocity verification failed");
        $finish;
    end

endmodule
